// ===== rtl/aes128_ecb_ctr_cipher_macros.svh =====
// Assertion macros shared by the cipher RTL
`ifndef AES128_ECB_CTR_CIPHER_MACROS_SVH
`define AES128_ECB_CTR_CIPHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define AES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define AES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/aes_pkg.sv =====
// Package: AES constants, S-box tables and round functions
`timescale 1ns / 1ps
package aes_pkg;

    localparam int MAX_ROUNDS = 10;
    localparam int RK_ROWS    = MAX_ROUNDS + 1;
    localparam int RK_AW      = $clog2(RK_ROWS);
    localparam int CFG_IW     = 3;

    typedef logic [1:0]        cmd_t;
    typedef logic [127:0]      blk_t;
    typedef logic [CFG_IW-1:0] cfg_idx_t;
    typedef logic [RK_AW-1:0]  rk_addr_t;

    localparam cmd_t CMD_ENC  = 2'd0;
    localparam cmd_t CMD_DEC  = 2'd1;
    localparam cmd_t CMD_CTR  = 2'd2;
    localparam cmd_t CMD_PASS = 2'd3;

    localparam cfg_idx_t REG_KEY_HIGH    = 3'd0;
    localparam cfg_idx_t REG_KEY_LOW     = 3'd1;
    localparam cfg_idx_t REG_NONCE_HIGH  = 3'd2;
    localparam cfg_idx_t REG_NONCE_LOW   = 3'd3;
    localparam cfg_idx_t REG_ROUND_COUNT = 3'd4;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1B;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // byte i of the block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input blk_t s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic blk_t sub_shift(input blk_t s, input logic inverse);
        blk_t t;
        int   src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inverse ? ((c + 4 - r) & 3) : ((c + r) & 3);
                t[127 - 8 * (4 * c + r) -: 8] = inverse ? INV_SBOX[get_byte(s, 4 * src + r)]
                                                        : FWD_SBOX[get_byte(s, 4 * src + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic blk_t mix_cols(input blk_t s);
        blk_t       t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                     a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                     a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                     xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        mix_cols = t;
    endfunction

    // 0e, 0b, 0d, 09 built from the doubling chain
    function automatic logic [7:0] mul9(input logic [7:0] a);
        mul9 = xtime(xtime(xtime(a))) ^ a;
    endfunction
    function automatic logic [7:0] mulb(input logic [7:0] a);
        mulb = xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction
    function automatic logic [7:0] muld(input logic [7:0] a);
        muld = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction
    function automatic logic [7:0] mule(input logic [7:0] a);
        mule = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic blk_t inv_mix_cols(input blk_t s);
        blk_t       t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            t[127 - 32 * c -: 32] = {mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3),
                                     mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3),
                                     muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3),
                                     mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3)};
        end
        inv_mix_cols = t;
    endfunction

    // one row of the key schedule: four words from the previous four
    function automatic blk_t key_step(input blk_t k, input logic [7:0] rcon);
        logic [31:0] t, w0, w1, w2, w3;
        t  = k[31:0];
        t  = {FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]], FWD_SBOX[t[31:24]]}
             ^ {rcon, 24'h000000};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/aes_blk_if.sv =====
// Interface: input block channel
`timescale 1ns / 1ps
interface aes_blk_if;
    import aes_pkg::*;
    logic        valid;
    logic        ready;
    cmd_t        command;
    logic        restart_counter;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, command, restart_counter, data_high, data_low, input ready);
    modport sink (input valid, command, restart_counter, data_high, data_low, output ready);
endinterface

// ===== rtl/aes_res_if.sv =====
// Interface: result block channel
`timescale 1ns / 1ps
interface aes_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== rtl/aes_cfg_if.sv =====
// Interface: configuration write channel
`timescale 1ns / 1ps
interface aes_cfg_if;
    import aes_pkg::*;
    logic        valid;
    logic        ready;
    cfg_idx_t    index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/aes128_ecb_ctr_cipher.sv =====
// Top level: AES-128 ECB/CTR cipher with round keys in a block memory
`timescale 1ns / 1ps
// Usage
//  cfg : register writes (key high/low, nonce high/low, round count), always ready.
//        A key write restarts the key schedule; users write config only while idle (not enforced).
//  blk : one word per 128-bit block with a command (encrypt, decrypt, CTR, pass).
//        Ready drops while a block is in flight or the key schedule runs.
//  res : one word per block, held in an output register until taken.
// Sequence
//  A block passes from accept through S_INIT (the initial key add), S_ROUND
//  (once per round, nr = clamped round count) and S_FIN into the output register;
//  the first key row is read at the accept edge. One round-key row is read from
//  the 11 x 128 key memory each cycle, and that read paces the round loop; one
//  block is in flight at a time, so a new block is taken only once the last one
//  has left S_FIN.
//  Pass-through blocks go from accept straight to S_FIN and the output register.
// Reset
//  The key schedule runs after reset and after each key write, filling the key
//  memory one row a cycle; blk is not ready meanwhile.
// Stall
//  While res is stalled the result waits; the next block may be accepted and
//  computed, and it waits for the output register to empty.
module aes128_ecb_ctr_cipher (
    input logic clk,
    input logic rst_n,
    aes_blk_if.sink blk,
    aes_res_if.source res,
    aes_cfg_if.sink cfg
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_ROUND, S_FIN} state_t;

    // configuration registers
    logic [63:0] key_high_reg, key_low_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [3:0]  round_count_reg;

    // key schedule
    logic        exp_pend_reg, exp_active_reg;
    rk_addr_t    exp_idx_reg;
    blk_t        exp_key_reg;
    logic [7:0]  rcon_reg;

    // key memory
    blk_t        rk_mem [RK_ROWS];
    blk_t        rk_rdata;
    logic        wr_en;
    rk_addr_t    wr_addr;
    blk_t        wr_data;
    rk_addr_t    rd_addr;

    // cipher datapath
    state_t      state_reg, state_next;
    cmd_t        mode_reg, mode_next;
    logic [3:0]  nr_reg, nr_next;
    logic [3:0]  step_reg, step_next;
    blk_t        st_reg, st_next;
    blk_t        data_reg, data_next;
    logic [31:0] ctr_reg, ctr_next;
    logic        out_valid_reg, out_valid_next;
    blk_t        out_reg, out_next;

    logic        cfg_fire, blk_fire, out_free, last_round;
    logic [3:0]  nr_cfg, nr_use, stepn, addr_raw;
    logic        dec_sel;
    logic [31:0] ctr_base;
    blk_t        fwd_t, enc_out, inv_t, dec_out;

    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;
    assign blk.ready = (state_reg == S_IDLE) && !exp_pend_reg && !exp_active_reg;
    assign blk_fire  = blk.valid && blk.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign res.valid       = out_valid_reg;
    assign res.result_high = out_reg[127:64];
    assign res.result_low  = out_reg[63:0];

    // zero rounds act as one, above the maximum saturate
    always_comb
    begin
        if (round_count_reg == 4'd0)
            nr_cfg = 4'd1;
        else if (round_count_reg > 4'(MAX_ROUNDS))
            nr_cfg = 4'(MAX_ROUNDS);
        else
            nr_cfg = round_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            nonce_high_reg  <= '0;
            nonce_low_reg   <= '0;
            round_count_reg <= 4'(MAX_ROUNDS);
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_KEY_HIGH:    key_high_reg    <= cfg.data;
                REG_KEY_LOW:     key_low_reg     <= cfg.data;
                REG_NONCE_HIGH:  nonce_high_reg  <= cfg.data[31:0];
                REG_NONCE_LOW:   nonce_low_reg   <= cfg.data;
                REG_ROUND_COUNT: round_count_reg <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // key schedule: row 0 is the key, then one row a cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {key_high_reg, key_low_reg};
        if (exp_pend_reg)
            wr_en = 1'b1;
        else if (exp_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = exp_idx_reg;
            wr_data = key_step(exp_key_reg, rcon_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pend_reg   <= 1'b1;
            exp_active_reg <= 1'b0;
            exp_idx_reg    <= '0;
            rcon_reg       <= RCON_FIRST;
            exp_key_reg    <= '0;
        end
        else
        begin
            if (exp_pend_reg)
            begin
                exp_active_reg <= 1'b1;
                exp_idx_reg    <= rk_addr_t'(1);
                rcon_reg       <= RCON_FIRST;
                exp_key_reg    <= wr_data;
            end
            else if (exp_active_reg)
            begin
                exp_key_reg <= wr_data;
                rcon_reg    <= xtime(rcon_reg);
                exp_idx_reg <= exp_idx_reg + rk_addr_t'(1);
                if (exp_idx_reg == rk_addr_t'(MAX_ROUNDS))
                    exp_active_reg <= 1'b0;
            end
            exp_pend_reg <= cfg_fire && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW);
        end
    end

    // read address runs one step ahead of the round that uses it
    always_comb
    begin
        nr_use   = (state_reg == S_IDLE) ? nr_cfg : nr_reg;
        dec_sel  = (state_reg == S_IDLE) ? (blk.command == CMD_DEC) : (mode_reg == CMD_DEC);
        stepn    = (state_reg == S_IDLE) ? 4'd0 : step_reg + 4'd1;
        addr_raw = dec_sel ? nr_use - stepn : stepn;
        rd_addr  = (addr_raw > 4'(MAX_ROUNDS)) ? '0 : rk_addr_t'(addr_raw);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rk_mem[wr_addr] <= wr_data;
        rk_rdata <= rk_mem[rd_addr];
    end

    // round datapath
    always_comb
    begin
        last_round = (step_reg == nr_reg);
        fwd_t      = sub_shift(st_reg, 1'b0);
        enc_out    = (last_round ? fwd_t : mix_cols(fwd_t)) ^ rk_rdata;
        inv_t      = sub_shift(st_reg, 1'b1) ^ rk_rdata;
        dec_out    = last_round ? inv_t : inv_mix_cols(inv_t);
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        nr_next        = nr_reg;
        step_next      = step_reg;
        st_next        = st_reg;
        data_next      = data_reg;
        ctr_next       = ctr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        ctr_base       = blk.restart_counter ? 32'd0 : ctr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (blk_fire)
                begin
                    mode_next = blk.command;
                    nr_next   = nr_cfg;
                    step_next = 4'd0;
                    data_next = {blk.data_high, blk.data_low};
                    ctr_next  = (blk.command == CMD_CTR) ? ctr_base + 32'd1 : ctr_base;
                    if (blk.command == CMD_CTR)
                        st_next = {nonce_high_reg, nonce_low_reg, ctr_base};
                    else
                        st_next = {blk.data_high, blk.data_low};
                    state_next = (blk.command == CMD_PASS) ? S_FIN : S_INIT;
                end
            end
            S_INIT:
            begin
                st_next    = st_reg ^ rk_rdata;
                step_next  = 4'd1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                st_next   = (mode_reg == CMD_DEC) ? dec_out : enc_out;
                step_next = step_reg + 4'd1;
                if (last_round)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = (mode_reg == CMD_CTR) ? st_reg ^ data_reg : st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        nr_reg   <= nr_next;
        step_reg <= step_next;
        st_reg   <= st_next;
        data_reg <= data_next;
        out_reg  <= out_next;
    end

`include "aes128_ecb_ctr_cipher_macros.svh"

    `AES_ASSERT_NOW(a_no_accept_during_schedule, blk.valid && blk.ready, !exp_pend_reg && !exp_active_reg)
    `AES_ASSERT_NEXT(a_key_write_restarts, cfg.valid && cfg.ready && cfg.index == REG_KEY_LOW, exp_pend_reg)
    `AES_ASSERT_NEXT(a_last_round_to_fin, state_reg == S_ROUND && step_reg == nr_reg, state_reg == S_FIN)

endmodule
